### src/atan2_fixed_approx_defines.svh
// ----------------------------------------------------------------------------
// atan2_fixed_approx_defines.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ATAN2_FIXED_APPROX_DEFINES_SVH
`define ATAN2_FIXED_APPROX_DEFINES_SVH

// same-cycle implication
`define AFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("afa assertion failed");

// next-cycle implication
`define AFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("afa assertion failed");

`endif

### src/afa_pkg.sv
// ----------------------------------------------------------------------------
// afa_pkg
// shared constants, types and width helpers of the atan2 pipeline
// ----------------------------------------------------------------------------
package afa_pkg;

   localparam int DEF_INPUT_WIDTH         = 16;
   localparam int DEF_ANGLE_FRACTION_BITS = 13;

   // magnitudes are scaled down below this many bits before the products
   localparam int MAG_LIMIT_BITS = 24;

   // 0.28 held as 287/1024
   localparam int COEF_NUM   = 287;
   localparam int COEF_SHIFT = 10;

   localparam int          PI_FRAC_BITS = 28;
   localparam logic [63:0] PI_Q28       = 64'd843314857;

   // register stages ahead of the divider
   localparam int PREP_STAGES = 5;

   typedef struct packed {
      logic x_zero;
      logic y_zero;
      logic y_small;
      logic y_neg;
      logic x_neg;
   } flags_type;

   function automatic int mag_width(input int iw);
      return (iw > MAG_LIMIT_BITS) ? MAG_LIMIT_BITS : iw;
   endfunction

   function automatic int den_width(input int iw);
      return 2 * mag_width(iw) + COEF_SHIFT + 1;
   endfunction

   function automatic logic [63:0] pi_scaled(input int frac_bits);
      return (((PI_Q28 << 1) >> (PI_FRAC_BITS - frac_bits)) + 64'd1) >> 1;
   endfunction

   function automatic logic [63:0] half_pi_scaled(input int frac_bits);
      return ((PI_Q28 >> (PI_FRAC_BITS - frac_bits)) + 64'd1) >> 1;
   endfunction

endpackage

### src/afa_prep.sv
// ----------------------------------------------------------------------------
// afa_prep
// front end: magnitudes, octant ordering, range scaling and the
// numerator / denominator products of the rational approximation
// ----------------------------------------------------------------------------
module afa_prep #(
   parameter int INPUT_WIDTH = afa_pkg::DEF_INPUT_WIDTH
) (
   input  logic                                          clock,
   input  logic [afa_pkg::PREP_STAGES-1:0]               load,
   input  logic signed [INPUT_WIDTH-1:0]                 y_value,
   input  logic signed [INPUT_WIDTH-1:0]                 x_value,
   output logic [afa_pkg::den_width(INPUT_WIDTH)-2:0]    num,
   output logic [afa_pkg::den_width(INPUT_WIDTH)-1:0]    den,
   output afa_pkg::flags_type                            flags
);
   import afa_pkg::*;

   localparam int IW      = INPUT_WIDTH;
   localparam int RED_W   = mag_width(IW);
   localparam int PROD_W  = 2 * RED_W;
   localparam int DEN_W   = den_width(IW);
   localparam int NUM_W   = DEN_W - 1;
   localparam int SHIFT_W = (IW > RED_W) ? $clog2(IW - RED_W + 1) : 1;

   // stage 0: sign and magnitude
   logic [IW-1:0] ym_in, xm_in, ym_ff, xm_ff;
   logic          yneg_ff, xneg_ff;

   always_comb begin
      ym_in = y_value[IW-1] ? IW'(~y_value + 1'b1) : IW'(y_value);
      xm_in = x_value[IW-1] ? IW'(~x_value + 1'b1) : IW'(x_value);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ym_ff   <= ym_in;
         xm_ff   <= xm_in;
         yneg_ff <= y_value[IW-1];
         xneg_ff <= x_value[IW-1];
      end
   end

   // stage 1: larger magnitude goes to a
   logic [IW-1:0] a1_in, b1_in, a1_ff, b1_ff;
   flags_type     flags1_in, flags1_ff;

   always_comb begin
      flags1_in.x_zero  = (xm_ff == '0);
      flags1_in.y_zero  = (ym_ff == '0);
      flags1_in.y_small = (ym_ff < xm_ff);
      flags1_in.y_neg   = yneg_ff;
      flags1_in.x_neg   = xneg_ff;
      a1_in = flags1_in.y_small ? xm_ff : ym_ff;
      b1_in = flags1_in.y_small ? ym_ff : xm_ff;
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         a1_ff     <= a1_in;
         b1_ff     <= b1_in;
         flags1_ff <= flags1_in;
      end
   end

   // stage 2: shift both down until a fits the product width
   logic [SHIFT_W-1:0] shift_amt;
   logic [IW-1:0]      a_shift, b_shift;
   logic [RED_W-1:0]   a2_ff, b2_ff;
   flags_type          flags2_ff;

   always_comb begin
      shift_amt = '0;
      for (int i = RED_W; i < IW; i++) begin
         if (a1_ff[i]) begin
            shift_amt = SHIFT_W'(i - RED_W + 1);
         end
      end
      a_shift = a1_ff >> shift_amt;
      b_shift = b1_ff >> shift_amt;
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         a2_ff     <= RED_W'(a_shift);
         b2_ff     <= RED_W'(b_shift);
         flags2_ff <= flags1_ff;
      end
   end

   // stage 3: squares and cross product
   logic [PROD_W-1:0] aa_ff, ab_ff, bb_ff;
   flags_type         flags3_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         aa_ff     <= PROD_W'(a2_ff) * PROD_W'(a2_ff);
         ab_ff     <= PROD_W'(a2_ff) * PROD_W'(b2_ff);
         bb_ff     <= PROD_W'(b2_ff) * PROD_W'(b2_ff);
         flags3_ff <= flags2_ff;
      end
   end

   // stage 4: num = 1024*a*b, den = 1024*a*a + 287*b*b
   logic [NUM_W-1:0] num_in, num_ff;
   logic [DEN_W-1:0] den_in, den_ff;
   flags_type        flags4_ff;

   always_comb begin
      num_in = NUM_W'(ab_ff) << COEF_SHIFT;
      den_in = (DEN_W'(aa_ff) << COEF_SHIFT) + DEN_W'(bb_ff) * DEN_W'(COEF_NUM);
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         num_ff    <= num_in;
         den_ff    <= den_in;
         flags4_ff <= flags3_ff;
      end
   end

   assign num   = num_ff;
   assign den   = den_ff;
   assign flags = flags4_ff;

endmodule

### src/afa_div_step.sv
// ----------------------------------------------------------------------------
// afa_div_step
// one registered restoring-division step: one quotient bit per stage
// ----------------------------------------------------------------------------
module afa_div_step #(
   parameter int DEN_WIDTH = afa_pkg::den_width(afa_pkg::DEF_INPUT_WIDTH),
   parameter int QUO_WIDTH = afa_pkg::DEF_ANGLE_FRACTION_BITS + 1
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [DEN_WIDTH-1:0]   prev_rem,
   input  logic [DEN_WIDTH-1:0]   prev_den,
   input  logic [QUO_WIDTH-1:0]   prev_quo,
   input  afa_pkg::flags_type     prev_flags,
   output logic [DEN_WIDTH-1:0]   step_rem,
   output logic [DEN_WIDTH-1:0]   step_den,
   output logic [QUO_WIDTH-1:0]   step_quo,
   output afa_pkg::flags_type     step_flags
);
   import afa_pkg::*;

   logic [DEN_WIDTH:0]   rem_dbl, rem_diff;
   logic                 fits;
   logic [DEN_WIDTH-1:0] rem_in, rem_ff, den_ff;
   logic [QUO_WIDTH-1:0] quo_in, quo_ff;
   flags_type            flags_ff;

   always_comb begin
      rem_dbl  = {prev_rem, 1'b0};
      rem_diff = rem_dbl - {1'b0, prev_den};
      fits     = (rem_dbl >= {1'b0, prev_den});
      // remainder stays below den, so the top bit drops either way
      rem_in   = fits ? rem_diff[DEN_WIDTH-1:0] : rem_dbl[DEN_WIDTH-1:0];
      quo_in   = {prev_quo[QUO_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff   <= rem_in;
         den_ff   <= prev_den;
         quo_ff   <= quo_in;
         flags_ff <= prev_flags;
      end
   end

   assign step_rem   = rem_ff;
   assign step_den   = den_ff;
   assign step_quo   = quo_ff;
   assign step_flags = flags_ff;

endmodule

### src/afa_finish.sv
// ----------------------------------------------------------------------------
// afa_finish
// rounds the quotient, applies signs and the quadrant offset, and holds
// the result in the output register
// ----------------------------------------------------------------------------
module afa_finish #(
   parameter int ANGLE_FRACTION_BITS = afa_pkg::DEF_ANGLE_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic [ANGLE_FRACTION_BITS:0]        quo,
   input  afa_pkg::flags_type                  flags,
   output logic signed [ANGLE_FRACTION_BITS+2:0] angle
);
   import afa_pkg::*;

   localparam int QUO_W = ANGLE_FRACTION_BITS + 1;
   localparam int AW    = ANGLE_FRACTION_BITS + 3;
   localparam logic [AW-1:0] PI_VAL   = AW'(pi_scaled(ANGLE_FRACTION_BITS));
   localparam logic [AW-1:0] HALF_VAL = AW'(half_pi_scaled(ANGLE_FRACTION_BITS));

   logic [QUO_W:0]   quo_inc;
   logic [AW-1:0]    mag, signed_mag, angle_in;
   logic signed [AW-1:0] angle_ff;

   always_comb begin
      // round half away from zero on the magnitude
      quo_inc    = {1'b0, quo} + 1'b1;
      mag        = AW'(quo_inc[QUO_W:1]);
      signed_mag = (flags.y_neg ^ flags.x_neg) ? (~mag + 1'b1) : mag;
      if (flags.x_zero) begin
         if (flags.y_zero) begin
            angle_in = '0;
         end else if (flags.y_neg) begin
            angle_in = ~HALF_VAL + 1'b1;
         end else begin
            angle_in = HALF_VAL;
         end
      end else if (flags.y_small) begin
         if (flags.x_neg && flags.y_neg) begin
            angle_in = signed_mag - PI_VAL;
         end else if (flags.x_neg) begin
            angle_in = signed_mag + PI_VAL;
         end else begin
            angle_in = signed_mag;
         end
      end else begin
         if (flags.y_neg) begin
            angle_in = HALF_VAL - signed_mag - PI_VAL;
         end else begin
            angle_in = HALF_VAL - signed_mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

### src/atan2_fixed_approx.sv
// datapath: prep stages, then one divider stage per quotient bit, then the finish register
// throughput: one beat per cycle while req_stall is low; each divider stage resolves one quotient bit
// a held result does not block the input until every stage holds a beat
// reset (synchronous) clears the stage valid bits only; data registers keep their contents
// ----------------------------------------------------------------------------
// atan2_fixed_approx
// pipelined four-quadrant arctangent, z/(1+0.28z^2) with one division
// ----------------------------------------------------------------------------
module atan2_fixed_approx #(
   parameter int INPUT_WIDTH         = afa_pkg::DEF_INPUT_WIDTH,
   parameter int ANGLE_FRACTION_BITS = afa_pkg::DEF_ANGLE_FRACTION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [INPUT_WIDTH-1:0]         req_y_value,
   input  logic signed [INPUT_WIDTH-1:0]         req_x_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ANGLE_FRACTION_BITS+2:0] rsp_angle
);
   import afa_pkg::*;

   localparam int DEN_W      = den_width(INPUT_WIDTH);
   localparam int NUM_W      = DEN_W - 1;
   localparam int QUO_W      = ANGLE_FRACTION_BITS + 1;
   localparam int NUM_STAGES = PREP_STAGES + QUO_W + 1;

   logic [NUM_STAGES-1:0] vld_ff, vld_in, take;

   // a stage moves unless it and everything after it are full and the output is stalled
   genvar g;
   generate
      for (g = 0; g < NUM_STAGES; g++) begin : g_take
         assign take[g] = !rsp_stall || !(&vld_ff[NUM_STAGES-1:g]);
      end
   endgenerate

   always_comb begin
      vld_in[0] = take[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = take[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !take[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   logic [NUM_W-1:0] prep_num;
   logic [DEN_W-1:0] rem_pipe [0:QUO_W];
   logic [DEN_W-1:0] den_pipe [0:QUO_W];
   logic [QUO_W-1:0] quo_pipe [0:QUO_W];
   flags_type        flags_pipe [0:QUO_W];

   afa_prep #(
      .INPUT_WIDTH (INPUT_WIDTH)
   ) u_prep (
      .clock   (clock),
      .load    (take[PREP_STAGES-1:0]),
      .y_value (req_y_value),
      .x_value (req_x_value),
      .num     (prep_num),
      .den     (den_pipe[0]),
      .flags   (flags_pipe[0])
   );

   // numerator is below the denominator, so the integer quotient is zero
   assign rem_pipe[0] = DEN_W'(prep_num);
   assign quo_pipe[0] = '0;

   generate
      for (g = 0; g < QUO_W; g++) begin : g_div
         afa_div_step #(
            .DEN_WIDTH (DEN_W),
            .QUO_WIDTH (QUO_W)
         ) u_step (
            .clock      (clock),
            .load       (take[PREP_STAGES+g]),
            .prev_rem   (rem_pipe[g]),
            .prev_den   (den_pipe[g]),
            .prev_quo   (quo_pipe[g]),
            .prev_flags (flags_pipe[g]),
            .step_rem   (rem_pipe[g+1]),
            .step_den   (den_pipe[g+1]),
            .step_quo   (quo_pipe[g+1]),
            .step_flags (flags_pipe[g+1])
         );
      end
   endgenerate

   afa_finish #(
      .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
   ) u_finish (
      .clock (clock),
      .load  (take[NUM_STAGES-1]),
      .quo   (quo_pipe[QUO_W]),
      .flags (flags_pipe[QUO_W]),
      .angle (rsp_angle)
   );

endmodule

### src/afa_checker.sv
// ----------------------------------------------------------------------------
// afa_checker
// port-level checks of the atan2 pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "atan2_fixed_approx_defines.svh"

module afa_checker #(
   parameter int ANGLE_FRACTION_BITS = afa_pkg::DEF_ANGLE_FRACTION_BITS
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [ANGLE_FRACTION_BITS+2:0] rsp_angle
);
   import afa_pkg::*;

   localparam int AW = ANGLE_FRACTION_BITS + 3;
   localparam logic signed [AW-1:0] PI_S     = AW'(pi_scaled(ANGLE_FRACTION_BITS));
   localparam logic signed [AW-1:0] NEG_PI_S = -PI_S;

   logic angle_ok;

   assign angle_ok = (rsp_angle >= NEG_PI_S) && (rsp_angle <= PI_S);

   // nothing comes out right after reset
   `AFA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // input only backs up when the output is blocked
   `AFA_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // every angle lies within [-pi, +pi]
   `AFA_ASSERT_NOW(a_angle_range, clock, reset, rsp_valid, angle_ok)

   // a held result stays put
   `AFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_angle))

endmodule

bind atan2_fixed_approx afa_checker #(
   .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
) u_afa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_angle (rsp_angle)
);
